/* sv/krt_pkg.sv */
package krt_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int OUT_CNT_W   = 7;

    // One stored record, key in the lowest bits
    typedef struct packed {
        logic [15:0]        wickets;
        logic [23:0]        runs;
        logic [15:0]        match_cnt;
        logic signed [31:0] key;
    } t_rec;

    typedef enum logic [2:0] {
        OP_ADD     = 3'd0,
        OP_SEARCH  = 3'd1,
        OP_UPDATE  = 3'd2,
        OP_HIGHEST = 3'd3,
        OP_DELETE  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MAX,
        S_SHIFT,
        S_DONE
    } t_state;

    // Result handed from the engine to the output stage
    typedef struct packed {
        logic [OUT_CNT_W-1:0] count;
        t_rec                 rec;
        t_status              status;
    } t_res;

endpackage

/* sv/krt_engine.sv */
module krt_engine
    import krt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_op  i_op,
    input  t_rec i_rec,
    output logic o_res_valid,
    input  logic i_res_ready,
    output t_res o_res
);

    // Record store: one write port, one registered read port
    t_rec r_mem [TABLE_DEPTH];
    t_rec r_rd;

    t_state             r_state, n_state;
    t_op                r_op, n_op;
    logic signed [31:0] r_key, n_key;
    logic [23:0]        r_run, n_run;
    logic [ADDR_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]   r_count, n_count;
    t_status            r_status, n_status;
    t_rec               r_rec, n_rec;

    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [ADDR_W-1:0] w_raddr;
    t_rec              w_wdata;
    logic              w_last;
    logic              w_more;
    logic              w_match;
    logic              w_room;

    // Entry under test is the last one held
    assign w_last  = (CNT_W'(r_idx) + CNT_W'(1)) == r_count;
    // A later record exists to move down
    assign w_more  = (CNT_W'(r_idx) + CNT_W'(2)) <= r_count;
    assign w_match = r_rd.key == r_key;
    assign w_room  = r_count < CNT_W'(TABLE_DEPTH);

    // Next state and working registers
    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_key    = r_key;
        n_run    = r_run;
        n_idx    = r_idx;
        n_count  = r_count;
        n_status = r_status;
        n_rec    = r_rec;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = i_op;
                    n_key    = i_rec.key;
                    n_run    = i_rec.runs;
                    n_idx    = '0;
                    n_status = ST_OK;
                    n_rec    = '0;
                    n_state  = S_DONE;
                    case (i_op)
                        OP_ADD: begin
                            if (w_room) begin
                                n_count = r_count + CNT_W'(1);
                            end else begin
                                n_status = ST_FULL;
                            end
                        end
                        OP_SEARCH, OP_UPDATE, OP_DELETE: begin
                            if (r_count == '0) begin
                                n_status = ST_NOT_FOUND;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_HIGHEST: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_state = S_MAX;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (w_match) begin
                    case (r_op)
                        OP_SEARCH: begin
                            n_rec   = r_rd;
                            n_state = S_DONE;
                        end
                        OP_DELETE: begin
                            n_state = S_SHIFT;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end else if (w_last) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_DONE;
                end else begin
                    n_idx = r_idx + ADDR_W'(1);
                end
            end
            S_MAX: begin
                // first entry seeds the best; later ones win only when strictly larger
                if (r_idx == '0 || r_rd.runs > r_rec.runs) begin
                    n_rec = r_rd;
                end
                if (w_last) begin
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + ADDR_W'(1);
                end
            end
            S_SHIFT: begin
                if (w_more) begin
                    n_idx = r_idx + ADDR_W'(1);
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Memory control and handshake outputs
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = r_rd;
        w_raddr = '0;
        case (r_state)
            S_IDLE: begin
                w_raddr = '0;
                w_waddr = r_count[ADDR_W-1:0];
                w_wdata = i_rec;
                w_we    = i_in_valid && (i_op == OP_ADD) && w_room;
            end
            S_SCAN: begin
                w_raddr      = r_idx + ADDR_W'(1);
                w_wdata.runs = r_run;
                w_we         = w_match && (r_op == OP_UPDATE);
            end
            S_MAX: begin
                w_raddr = r_idx + ADDR_W'(1);
            end
            S_SHIFT: begin
                // read data holds the entry one above; move it down
                w_raddr = r_idx + ADDR_W'(2);
                w_we    = w_more;
            end
            default: begin
                w_raddr = '0;
            end
        endcase
    end

    assign o_in_ready   = r_state == S_IDLE;
    assign o_res_valid  = r_state == S_DONE;
    assign o_res.status = r_status;
    assign o_res.rec    = r_rec;
    assign o_res.count  = OUT_CNT_W'(r_count);

    // Store access
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_key    <= n_key;
        r_run    <= n_run;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_rec    <= n_rec;
    end

endmodule

/* sv/keyed_record_table_top.sv */
// Channel   Dir  Signals                       Contents
// s_axis    in   tvalid tready tuser tdata     one command word
// m_axis    out  tvalid tready tuser tdata     one result word per command
//
// Add writes the record directly. Search and update walk the table up to the match,
// highest and a missed lookup walk every record, and delete walks to the match and then
// moves each later entry down: the store has one read port and the walk reads one entry a cycle.
// Reset clears the record count and the handshakes; stored entries are kept.
// A finished result waits in the output register while the next command is
// taken; the engine stalls after its walk until that register frees.
module keyed_record_table_top
    import krt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [2:0]  s_axis_tuser,  // opcode
    input  logic [87:0] s_axis_tdata,  // record_key, match_count, run_total, wicket_count
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [1:0]  m_axis_tuser,  // status
    output logic [95:0] m_axis_tdata   // found_key, found_matches, found_runs,
                                       // found_wickets, record_count, zero pad
);

    logic r_out_valid;
    t_res r_out;
    t_res w_res;
    logic w_res_valid;
    logic w_res_ready;

    // Output register frees when empty or drained this cycle
    assign w_res_ready = !r_out_valid || m_axis_tready;

    krt_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_op        (t_op'(s_axis_tuser)),
        .i_rec       (t_rec'(s_axis_tdata)),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    // Hold the result word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {1'b0, r_out.count, r_out.rec};

endmodule

/* sv/krt_checker.sv */
module krt_checker
    import krt_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [1:0]  m_axis_tuser,
    input logic [95:0] m_axis_tdata
);

    // Stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result word changed under stall");

    // One command at a time: ready drops after a command word is taken
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("command taken while another is in flight");

    // Failed commands return no record
    a_no_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata[87:0] == '0)
        else $error("record fields set on failed command");

    // Full is reported only at capacity
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_FULL |->
            m_axis_tdata[94:88] == OUT_CNT_W'(TABLE_DEPTH))
        else $error("full reported below capacity");

    // Empty is reported only with no records
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_EMPTY |-> m_axis_tdata[94:88] == '0)
        else $error("empty reported with records held");

endmodule

bind keyed_record_table_top krt_checker u_krt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
);
